>>> design/qcap_pkg.sv
// Package: shared types, constants and arithmetic helpers for the attitude PID mixer.
`timescale 1ns / 1ps
package qcap_pkg;

  // Default tuning limits, integer units
  localparam int QCAP_OUTER_INT_LIMIT = 500;
  localparam int QCAP_INNER_INT_LIMIT = 500;
  localparam int QCAP_PID_OUT_LIMIT   = 100;
  localparam int QCAP_MOTOR_LOW       = 0;
  localparam int QCAP_MOTOR_HIGH      = 100;

  // Fixed safety thresholds
  localparam int QCAP_TILT_MAX      = 65;
  localparam int QCAP_THROTTLE_STOP = 10;

  // Register reset values
  localparam logic [31:0] RST_OUTER_KP = 32'd524288;
  localparam logic [31:0] RST_OUTER_KI = 32'd1311;
  localparam logic [31:0] RST_INNER_KP = 32'd8520;
  localparam logic [31:0] RST_INNER_KI = 32'd0;
  localparam logic [31:0] RST_INNER_KD = 32'd655;
  localparam logic [31:0] RST_YAW_KP   = 32'd9830;
  localparam logic [31:0] RST_YAW_KI   = 32'd0;
  localparam logic [31:0] RST_YAW_KD   = 32'd0;

  localparam logic signed [47:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] S48_MIN = 48'sh8000_0000_0000;

  typedef enum logic [2:0] {
    REG_OUTER_KP, REG_OUTER_KI, REG_INNER_KP, REG_INNER_KI,
    REG_INNER_KD, REG_YAW_KP, REG_YAW_KI, REG_YAW_KD
  } qcap_reg_t;

  typedef enum logic [2:0] {
    L_ROLL_OUT, L_ROLL_IN, L_PITCH_OUT, L_PITCH_IN, L_YAW
  } loop_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ERR, S_INTEG, S_MUL_I, S_MUL_D, S_MUL_P, S_MIX, S_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    M_IDLE, M_HI, M_LO, M_FIN
  } mul_state_t;

  typedef struct packed {
    logic [31:0] outer_kp;
    logic [31:0] outer_ki;
    logic [31:0] inner_kp;
    logic [31:0] inner_ki;
    logic [31:0] inner_kd;
    logic [31:0] yaw_kp;
    logic [31:0] yaw_ki;
    logic [31:0] yaw_kd;
  } gains_t;

  typedef struct packed {
    logic [31:0] target_roll;
    logic [31:0] target_pitch;
    logic [31:0] target_yaw_rate;
    logic [6:0]  throttle;
    logic [31:0] angle_roll;
    logic [31:0] angle_pitch;
    logic [31:0] rate_x;
    logic [31:0] rate_y;
    logic [31:0] rate_z;
  } in_item_t;

  typedef struct packed {
    logic [31:0] motor_one;
    logic [31:0] motor_two;
    logic [31:0] motor_three;
    logic [31:0] motor_four;
    logic        cut_off;
  } out_item_t;

  // Request and response of the shared multiplier
  typedef struct packed {
    logic        start;
    logic [47:0] a;
    logic [31:0] k;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] p;
  } mul_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -50'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    if (v > 50'(S48_MAX)) begin
      return S48_MAX;
    end else if (v < 50'(S48_MIN)) begin
      return S48_MIN;
    end
    return v[47:0];
  endfunction

  // Integrator that only moves back toward zero once beyond its limit
  function automatic logic signed [47:0] integrate(input logic signed [47:0] sum,
                                                   input logic signed [31:0] e,
                                                   input logic signed [47:0] lim);
    logic signed [49:0] s;
    s = 50'(sum);
    if (sum > lim) begin
      if (e < 0) s = 50'(sum) + 50'(e);
    end else if (sum < -lim) begin
      if (e > 0) s = 50'(sum) + 50'(e);
    end else begin
      s = 50'(sum) + 50'(e);
    end
    return sat48(s);
  endfunction

  // Negate flags {pitch, roll, yaw} for each motor of the X mixer
  function automatic logic [2:0] mix_sign(input logic [1:0] idx);
    logic [2:0] s;
    unique case (idx)
      2'd0:    s = 3'b011;
      2'd1:    s = 3'b000;
      2'd2:    s = 3'b101;
      default: s = 3'b110;
    endcase
    return s;
  endfunction

endpackage

>>> design/qcap_in_if.sv
// Interface: input channel carrying one control tick of targets and sensor data.
`timescale 1ns / 1ps
interface qcap_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] target_roll;
  logic [31:0] target_pitch;
  logic [31:0] target_yaw_rate;
  logic [6:0]  throttle;
  logic [31:0] angle_roll;
  logic [31:0] angle_pitch;
  logic [31:0] rate_x;
  logic [31:0] rate_y;
  logic [31:0] rate_z;

  modport source (output valid, target_roll, target_pitch, target_yaw_rate, throttle,
                  angle_roll, angle_pitch, rate_x, rate_y, rate_z, input ready);
  modport sink (input valid, target_roll, target_pitch, target_yaw_rate, throttle,
                angle_roll, angle_pitch, rate_x, rate_y, rate_z, output ready);
endinterface

>>> design/qcap_out_if.sv
// Interface: output channel carrying the four motor commands and the cut-off flag.
`timescale 1ns / 1ps
interface qcap_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] motor_one;
  logic [31:0] motor_two;
  logic [31:0] motor_three;
  logic [31:0] motor_four;
  logic        cut_off;

  modport source (output valid, motor_one, motor_two, motor_three, motor_four, cut_off,
                  input ready);
  modport sink (input valid, motor_one, motor_two, motor_three, motor_four, cut_off,
                output ready);
endinterface

>>> design/qcap_mul.sv
// Shared Q16.16 gain multiplier: magnitude times gain, shifted and saturated.
`timescale 1ns / 1ps
module qcap_mul
  import qcap_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  mul_state_t  state;
  logic        neg;
  logic [47:0] mag;
  logic [31:0] k;
  logic [63:0] hp;
  logic [47:0] lop;
  logic [47:0] p;
  logic        done;

  logic [31:0] mult_a;
  logic [63:0] prod;
  logic [47:0] low_sum;
  logic [47:0] res;

  // One 32x32 multiplier, fed the high then the low half of the magnitude
  assign mult_a = (state == M_HI) ? mag[47:16] : {16'd0, mag[15:0]};
  assign prod   = 64'(mult_a) * 64'(k);

  // Combine halves and saturate to 2^47-1
  always_comb begin
    low_sum = {1'b0, hp[46:0]} + 48'(lop[47:16]);
    if (hp[63:47] != 17'd0 || low_sum[47]) begin
      res = S48_MAX;
    end else begin
      res = low_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (req.start) begin
            neg   <= req.a[47];
            mag   <= req.a[47] ? (~req.a + 48'd1) : req.a;
            k     <= req.k;
            state <= M_HI;
          end
        end
        M_HI: begin
          hp    <= prod;
          state <= M_LO;
        end
        M_LO: begin
          lop   <= prod[47:0];
          state <= M_FIN;
        end
        M_FIN: begin
          p     <= neg ? (~res + 48'd1) : res;
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.p    = p;

endmodule

>>> design/qcap_seq.sv
// Sequencer: runs the five PID loops and the mixer through the shared multiplier.
`timescale 1ns / 1ps
module qcap_seq
  import qcap_pkg::*;
#(
  parameter int OUTER_INT_LIMIT = QCAP_OUTER_INT_LIMIT,
  parameter int INNER_INT_LIMIT = QCAP_INNER_INT_LIMIT,
  parameter int PID_OUT_LIMIT   = QCAP_PID_OUT_LIMIT,
  parameter int MOTOR_LOW       = QCAP_MOTOR_LOW,
  parameter int MOTOR_HIGH      = QCAP_MOTOR_HIGH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  item_in,
  input  gains_t    gains,
  output logic      idle,
  output logic      res_valid,
  input  logic      res_ready,
  output out_item_t res
);

  localparam logic signed [47:0] OUTER_LIM = 48'(longint'(OUTER_INT_LIMIT) * 65536);
  localparam logic signed [47:0] INNER_LIM = 48'(longint'(INNER_INT_LIMIT) * 65536);
  localparam logic signed [47:0] PID_LIM   = 48'(longint'(PID_OUT_LIMIT) * 65536);
  localparam logic signed [35:0] MOT_LO    = 36'(longint'(MOTOR_LOW) * 65536);
  localparam logic signed [35:0] MOT_HI    = 36'(longint'(MOTOR_HIGH) * 65536);
  localparam logic signed [31:0] TILT      = 32'(QCAP_TILT_MAX * 65536);

  seq_state_t state, state_next;
  in_item_t   item;
  logic       cut;
  loop_t      loop;
  logic       issued;
  logic [1:0] midx;

  logic signed [31:0] e;
  logic signed [47:0] sum [5];
  logic signed [31:0] prev [5];
  logic signed [49:0] acc;
  logic signed [47:0] outer_out;
  logic signed [31:0] pid_r, pid_p, pid_y;
  logic [31:0]        motors [4];

  mul_req_t mreq;
  mul_rsp_t mrsp;

  logic signed [47:0] err_a;
  logic signed [31:0] err_b;
  logic               err_sub;
  logic signed [49:0] err_sum;
  logic               is_outer;
  logic [31:0]        kp_sel, ki_sel, kd_sel;
  logic signed [32:0] d_err;
  logic signed [47:0] mp;
  logic signed [31:0] pid_clamped;
  logic [2:0]         msign;
  logic signed [35:0] mix_sum;
  logic signed [31:0] mix_out;

  qcap_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  assign mp       = $signed(mrsp.p);
  assign is_outer = (loop == L_ROLL_OUT) || (loop == L_PITCH_OUT);

  // Error operands and gains for the current loop
  always_comb begin
    unique case (loop)
      L_ROLL_OUT: begin
        err_a = 48'($signed(item.target_roll)); err_b = $signed(item.angle_roll);
        err_sub = 1'b1;
        kp_sel = gains.outer_kp; ki_sel = gains.outer_ki; kd_sel = gains.inner_kd;
      end
      L_ROLL_IN: begin
        err_a = outer_out; err_b = $signed(item.rate_x); err_sub = 1'b0;
        kp_sel = gains.inner_kp; ki_sel = gains.inner_ki; kd_sel = gains.inner_kd;
      end
      L_PITCH_OUT: begin
        err_a = 48'($signed(item.target_pitch)); err_b = $signed(item.angle_pitch);
        err_sub = 1'b1;
        kp_sel = gains.outer_kp; ki_sel = gains.outer_ki; kd_sel = gains.inner_kd;
      end
      L_PITCH_IN: begin
        err_a = outer_out; err_b = $signed(item.rate_y); err_sub = 1'b1;
        kp_sel = gains.inner_kp; ki_sel = gains.inner_ki; kd_sel = gains.inner_kd;
      end
      default: begin
        err_a = 48'($signed(item.target_yaw_rate)); err_b = $signed(item.rate_z);
        err_sub = 1'b1;
        kp_sel = gains.yaw_kp; ki_sel = gains.yaw_ki; kd_sel = gains.yaw_kd;
      end
    endcase
    err_sum = err_sub ? (50'(err_a) - 50'(err_b)) : (50'(err_a) + 50'(err_b));
  end

  assign d_err = 33'(e) - 33'(prev[loop]);

  // Multiplier request per phase
  always_comb begin
    mreq.start = 1'b0;
    mreq.a     = '0;
    mreq.k     = '0;
    unique case (state)
      S_MUL_I: begin
        mreq.start = !issued; mreq.a = sum[loop]; mreq.k = ki_sel;
      end
      S_MUL_D: begin
        mreq.start = !issued; mreq.a = 48'(d_err); mreq.k = kd_sel;
      end
      S_MUL_P: begin
        mreq.start = !issued; mreq.a = sat48(acc); mreq.k = kp_sel;
      end
      default: ;
    endcase
  end

  // Rate loop output clamp
  always_comb begin
    if (mp < -PID_LIM) begin
      pid_clamped = 32'(-PID_LIM);
    end else if (mp > PID_LIM) begin
      pid_clamped = 32'(PID_LIM);
    end else begin
      pid_clamped = mp[31:0];
    end
  end

  // One motor of the X mixer per cycle
  always_comb begin
    msign   = mix_sign(midx);
    mix_sum = 36'({1'b0, item.throttle, 16'd0})
            + (msign[2] ? -36'(pid_p) : 36'(pid_p))
            + (msign[1] ? -36'(pid_r) : 36'(pid_r))
            + (msign[0] ? -36'(pid_y) : 36'(pid_y));
    if (cut || mix_sum < MOT_LO) begin
      mix_out = 32'(MOT_LO);
    end else if (mix_sum > MOT_HI) begin
      mix_out = 32'(MOT_HI);
    end else begin
      mix_out = mix_sum[31:0];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) state_next = S_ERR;
      S_ERR:   state_next = S_INTEG;
      S_INTEG: state_next = S_MUL_I;
      S_MUL_I: if (mrsp.done) state_next = is_outer ? S_MUL_P : S_MUL_D;
      S_MUL_D: if (mrsp.done) state_next = S_MUL_P;
      S_MUL_P: if (mrsp.done) state_next = (loop == L_YAW) ? S_MIX : S_ERR;
      S_MIX:   if (midx == 2'd3) state_next = S_DONE;
      S_DONE:  if (res_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      issued <= 1'b0;
      loop   <= L_ROLL_OUT;
      midx   <= 2'd0;
      for (int i = 0; i < 5; i++) begin
        sum[i]  <= '0;
        prev[i] <= '0;
      end
    end else begin
      if (mreq.start) issued <= 1'b1;
      if (mrsp.done) issued <= 1'b0;
      unique case (state)
        S_IDLE: begin
          loop <= L_ROLL_OUT;
          midx <= 2'd0;
        end
        S_INTEG: begin
          sum[loop] <= integrate(sum[loop], e, is_outer ? OUTER_LIM : INNER_LIM);
        end
        S_MUL_P: begin
          if (mrsp.done) begin
            if (!is_outer) prev[loop] <= e;
            if (loop != L_YAW) loop <= loop_t'(loop + 3'd1);
          end
        end
        S_MIX: midx <= midx + 2'd1;
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          item <= item_in;
          cut  <= (item_in.throttle <= 7'(QCAP_THROTTLE_STOP))
               || ($signed(item_in.angle_pitch) >= TILT)
               || ($signed(item_in.angle_pitch) <= -TILT)
               || ($signed(item_in.angle_roll) >= TILT)
               || ($signed(item_in.angle_roll) <= -TILT);
        end
      end
      S_ERR:   e   <= sat32(err_sum);
      S_INTEG: acc <= 50'(e);
      S_MUL_I: if (mrsp.done) acc <= acc + 50'(mp);
      S_MUL_D: if (mrsp.done) acc <= acc + 50'(mp);
      S_MUL_P: begin
        if (mrsp.done) begin
          unique case (loop)
            L_ROLL_OUT, L_PITCH_OUT: outer_out <= mp;
            L_ROLL_IN:  pid_r <= pid_clamped;
            L_PITCH_IN: pid_p <= pid_clamped;
            default:    pid_y <= pid_clamped;
          endcase
        end
      end
      S_MIX: motors[midx] <= mix_out;
      default: ;
    endcase
  end

  assign idle            = (state == S_IDLE);
  assign res_valid       = (state == S_DONE);
  assign res.motor_one   = motors[0];
  assign res.motor_two   = motors[1];
  assign res.motor_three = motors[2];
  assign res.motor_four  = motors[3];
  assign res.cut_off     = cut;

endmodule

>>> design/quad_cascaded_attitude_pid_mixer_top.sv
// Top level: cascaded attitude PID controller with X-form quad motor mixer.
//
// One input transaction per control tick on in_ch carries attitude targets,
// throttle, measured angles and gyro rates; one output transaction on out_ch
// returns the four clamped motor commands and the cut-off flag.
// The user must write gains through cfg_we / cfg_index / cfg_data
// while idle; the block itself does not enforce this. Five PID loops run
// one after another, each through the setup states S_ERR and S_INTEG and
// then two or three passes through one shared 32x32 multiplier (states
// M_IDLE, M_HI, M_LO and M_FIN per product), then the mixing of the four
// motors and the move of the result into the output register.
// in_ch.ready is high only while the sequencer is idle. The result moves to
// an output register, so the next tick is accepted while a result still waits
// on out_ch; a stalled receiver holds out_ch and, once a second result is
// done, holds the sequencer until the register frees up.
// Synchronous reset restores the default gains, clears all integrators and
// last errors, and empties the output register.
`timescale 1ns / 1ps
module quad_cascaded_attitude_pid_mixer_top
  import qcap_pkg::*;
#(
  parameter int OUTER_INT_LIMIT = QCAP_OUTER_INT_LIMIT,
  parameter int INNER_INT_LIMIT = QCAP_INNER_INT_LIMIT,
  parameter int PID_OUT_LIMIT   = QCAP_PID_OUT_LIMIT,
  parameter int MOTOR_LOW       = QCAP_MOTOR_LOW,
  parameter int MOTOR_HIGH      = QCAP_MOTOR_HIGH
) (
  input  logic        clk,
  input  logic        rst,
  qcap_in_if.sink     in_ch,
  qcap_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  gains_t    gains;
  in_item_t  item_in;
  out_item_t res;
  logic      idle;
  logic      res_valid;
  logic      res_ready;
  logic      out_valid;
  out_item_t out_data;

  // Gain registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gains.outer_kp <= RST_OUTER_KP;
      gains.outer_ki <= RST_OUTER_KI;
      gains.inner_kp <= RST_INNER_KP;
      gains.inner_ki <= RST_INNER_KI;
      gains.inner_kd <= RST_INNER_KD;
      gains.yaw_kp   <= RST_YAW_KP;
      gains.yaw_ki   <= RST_YAW_KI;
      gains.yaw_kd   <= RST_YAW_KD;
    end else if (cfg_we) begin
      unique case (qcap_reg_t'(cfg_index))
        REG_OUTER_KP: gains.outer_kp <= cfg_data;
        REG_OUTER_KI: gains.outer_ki <= cfg_data;
        REG_INNER_KP: gains.inner_kp <= cfg_data;
        REG_INNER_KI: gains.inner_ki <= cfg_data;
        REG_INNER_KD: gains.inner_kd <= cfg_data;
        REG_YAW_KP:   gains.yaw_kp   <= cfg_data;
        REG_YAW_KI:   gains.yaw_ki   <= cfg_data;
        REG_YAW_KD:   gains.yaw_kd   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input payload
  assign item_in.target_roll     = in_ch.target_roll;
  assign item_in.target_pitch    = in_ch.target_pitch;
  assign item_in.target_yaw_rate = in_ch.target_yaw_rate;
  assign item_in.throttle        = in_ch.throttle;
  assign item_in.angle_roll      = in_ch.angle_roll;
  assign item_in.angle_pitch     = in_ch.angle_pitch;
  assign item_in.rate_x          = in_ch.rate_x;
  assign item_in.rate_y          = in_ch.rate_y;
  assign item_in.rate_z          = in_ch.rate_z;
  assign in_ch.ready             = idle;

  qcap_seq #(
    .OUTER_INT_LIMIT (OUTER_INT_LIMIT),
    .INNER_INT_LIMIT (INNER_INT_LIMIT),
    .PID_OUT_LIMIT   (PID_OUT_LIMIT),
    .MOTOR_LOW       (MOTOR_LOW),
    .MOTOR_HIGH      (MOTOR_HIGH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (in_ch.valid && idle),
    .item_in   (item_in),
    .gains     (gains),
    .idle      (idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register
  assign res_ready = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_data <= res;
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.motor_one   = out_data.motor_one;
  assign out_ch.motor_two   = out_data.motor_two;
  assign out_ch.motor_three = out_data.motor_three;
  assign out_ch.motor_four  = out_data.motor_four;
  assign out_ch.cut_off     = out_data.cut_off;

endmodule
